[rtl/i2p_pkg.sv]
// Package for the infix to postfix converter: character codes, symbol
// classes, controller states and the command/status bundles.
// No dependencies.
`default_nettype none

package i2p_pkg;

   localparam logic [7:0] CHAR_OPEN  = 8'h28;  // '('
   localparam logic [7:0] CHAR_CLOSE = 8'h29;  // ')'
   localparam logic [7:0] CHAR_PLUS  = 8'h2B;  // '+'
   localparam logic [7:0] CHAR_MINUS = 8'h2D;  // '-'
   localparam logic [7:0] CHAR_MUL   = 8'h2A;  // '*'
   localparam logic [7:0] CHAR_DIV   = 8'h2F;  // '/'
   localparam logic [7:0] CHAR_DOLL  = 8'h24;  // '$'
   localparam logic [7:0] CHAR_CARET = 8'h5E;  // '^'

   localparam logic [1:0] ERR_NONE     = 2'd0;
   localparam logic [1:0] ERR_OVERFLOW = 2'd1;
   localparam logic [1:0] ERR_UNKNOWN  = 2'd2;

   typedef enum logic [2:0] {
      SYM_END,
      SYM_OPERAND,
      SYM_OPEN,
      SYM_CLOSE,
      SYM_OPER,
      SYM_UNKNOWN
   } sym_class_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DECODE,
      ST_READ,
      ST_CHECK,
      ST_PUSH,
      ST_TERM,
      ST_FINISH
   } state_type;

   typedef struct packed {
      logic capture;
      logic push;
      logic pop;
      logic emit_top;
      logic emit_sym;
      logic emit_term;
      logic finish;
      logic set_unknown;
   } ctl_cmd_type;

   typedef struct packed {
      sym_class_type kind;
      logic          count_zero;
      logic          count_one;
      logic          top_is_open;
      logic          top_ge;
      logic          emit_ok;
      logic          finish_ok;
   } ctl_stat_type;

   // Precedence: '(' and non-operators 0, + - 1, * / 2, $ ^ 3.
   function automatic logic [1:0] prec_of(input logic [7:0] c);
      logic [1:0] p;
      case (c)
         CHAR_PLUS, CHAR_MINUS: p = 2'd1;
         CHAR_MUL, CHAR_DIV:    p = 2'd2;
         CHAR_DOLL, CHAR_CARET: p = 2'd3;
         default:               p = 2'd0;
      endcase
      return p;
   endfunction

   function automatic sym_class_type classify(input logic [7:0] c, input logic is_end);
      sym_class_type k;
      if (is_end) begin
         k = SYM_END;
      end else if ((c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h5A) ||
                   (c >= 8'h61 && c <= 8'h7A)) begin
         k = SYM_OPERAND;
      end else if (c == CHAR_OPEN) begin
         k = SYM_OPEN;
      end else if (c == CHAR_CLOSE) begin
         k = SYM_CLOSE;
      end else if (prec_of(c) != 2'd0) begin
         k = SYM_OPER;
      end else begin
         k = SYM_UNKNOWN;
      end
      return k;
   endfunction

endpackage

`default_nettype wire

[rtl/i2p_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module i2p_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

[rtl/i2p_ctrl.sv]
// Sequencer for the converter: walks decode, stack reads, pops, push and
// result hand-off. Depends on i2p_pkg.
`default_nettype none

module i2p_ctrl (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output logic                      req_ready,
   input  wire i2p_pkg::ctl_stat_type stat,
   output i2p_pkg::ctl_cmd_type      cmd
);
   import i2p_pkg::*;

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) state_in = ST_DECODE;
         end
         ST_DECODE: begin
            case (stat.kind)
               SYM_END:     state_in = stat.count_zero ? ST_TERM : ST_READ;
               SYM_OPERAND: state_in = stat.emit_ok ? ST_FINISH : ST_DECODE;
               SYM_CLOSE:   state_in = stat.count_zero ? ST_IDLE : ST_READ;
               SYM_OPER:    state_in = stat.count_zero ? ST_IDLE : ST_READ;
               default:     state_in = ST_IDLE;
            endcase
         end
         ST_READ: state_in = ST_CHECK;
         ST_CHECK: begin
            case (stat.kind)
               SYM_END: begin
                  if (stat.emit_ok) state_in = stat.count_one ? ST_TERM : ST_READ;
               end
               SYM_CLOSE: begin
                  if (stat.top_is_open) begin
                     state_in = ST_FINISH;
                  end else if (stat.emit_ok) begin
                     state_in = stat.count_one ? ST_FINISH : ST_READ;
                  end
               end
               SYM_OPER: begin
                  if (!stat.top_ge) begin
                     state_in = ST_PUSH;
                  end else if (stat.emit_ok) begin
                     state_in = stat.count_one ? ST_PUSH : ST_READ;
                  end
               end
               default: state_in = ST_IDLE;
            endcase
         end
         ST_PUSH: state_in = ST_FINISH;
         ST_TERM: begin
            if (stat.emit_ok) state_in = ST_FINISH;
         end
         ST_FINISH: begin
            if (stat.finish_ok) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready   = 1'b1;
            cmd.capture = 1'b1;
         end
         ST_DECODE: begin
            case (stat.kind)
               SYM_OPERAND: cmd.emit_sym    = stat.emit_ok;
               SYM_OPEN:    cmd.push        = 1'b1;
               SYM_OPER:    cmd.push        = stat.count_zero;
               SYM_UNKNOWN: cmd.set_unknown = 1'b1;
               default:     cmd             = '0;
            endcase
         end
         ST_CHECK: begin
            case (stat.kind)
               SYM_END: begin
                  cmd.emit_top = stat.emit_ok;
                  cmd.pop      = stat.emit_ok;
               end
               SYM_CLOSE: begin
                  cmd.emit_top = !stat.top_is_open && stat.emit_ok;
                  cmd.pop      = stat.top_is_open || stat.emit_ok;
               end
               SYM_OPER: begin
                  cmd.emit_top = stat.top_ge && stat.emit_ok;
                  cmd.pop      = stat.top_ge && stat.emit_ok;
               end
               default: cmd = '0;
            endcase
         end
         ST_PUSH:   cmd.push      = 1'b1;
         ST_TERM:   cmd.emit_term = stat.emit_ok;
         ST_FINISH: cmd.finish    = stat.finish_ok;
         default:   cmd           = '0;
      endcase
   end

endmodule

`default_nettype wire

[rtl/i2p_datapath.sv]
// Datapath for the converter: held input item, operator stack RAM, count,
// error flags, one pending result and the result register.
// Depends on i2p_pkg and i2p_ram.
`default_nettype none

module i2p_datapath #(
   parameter int STACK_DEPTH = 32
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic [7:0]           req_symbol,
   input  wire logic                 req_is_end,
   input  wire i2p_pkg::ctl_cmd_type  cmd,
   output i2p_pkg::ctl_stat_type     stat,
   output logic                      rsp_valid,
   input  wire logic                 rsp_ready,
   output logic      [7:0]           rsp_out_char,
   output logic                      rsp_last_of_run,
   output logic                      rsp_end_of_expr,
   output logic      [1:0]           rsp_error_code
);
   import i2p_pkg::*;

   localparam int CW = $clog2(STACK_DEPTH + 1);
   localparam int AW = $clog2(STACK_DEPTH);

   logic [7:0]    sym_ff;
   logic          end_ff;
   logic [CW-1:0] count_ff, count_in;
   logic [CW-1:0] count_m1;
   logic          ovf_ff, ovf_in;
   logic          unk_ff, unk_in;
   logic          full;
   logic [7:0]    top;
   logic [1:0]    term_err;

   logic          pend_valid_ff, pend_valid_in;
   logic [7:0]    pend_char_ff, pend_char_in;
   logic          pend_end_ff, pend_end_in;
   logic [1:0]    pend_err_ff, pend_err_in;

   logic          out_valid_ff, out_valid_in;
   logic [7:0]    out_char_ff;
   logic          out_last_ff;
   logic          out_end_ff;
   logic [1:0]    out_err_ff;
   logic          out_free;
   logic          emit_any;
   logic          move;
   logic          move_last;

   assign full     = (count_ff == CW'(STACK_DEPTH));
   assign count_m1 = count_ff - CW'(1);

   i2p_ram #(
      .WIDTH (8),
      .DEPTH (STACK_DEPTH)
   ) u_stack (
      .clock   (clock),
      .wr_en   (cmd.push && !full),
      .wr_addr (count_ff[AW-1:0]),
      .wr_data (sym_ff),
      .rd_addr (count_m1[AW-1:0]),
      .rd_data (top)
   );

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         sym_ff <= req_symbol;
         end_ff <= req_is_end;
      end
   end

   always_comb begin
      count_in = count_ff;
      if (cmd.push && !full) begin
         count_in = count_ff + CW'(1);
      end else if (cmd.pop) begin
         count_in = count_m1;
      end
      ovf_in = ovf_ff | (cmd.push & full);
      unk_in = unk_ff | cmd.set_unknown;
      if (cmd.emit_term) begin
         ovf_in = 1'b0;
         unk_in = 1'b0;
      end
   end

   assign term_err = ovf_ff ? ERR_OVERFLOW : (unk_ff ? ERR_UNKNOWN : ERR_NONE);

   assign out_free  = !out_valid_ff || rsp_ready;
   assign emit_any  = cmd.emit_top | cmd.emit_sym | cmd.emit_term;
   assign move      = pend_valid_ff && (emit_any || cmd.finish);
   assign move_last = cmd.finish;

   always_comb begin
      pend_valid_in = pend_valid_ff;
      pend_char_in  = pend_char_ff;
      pend_end_in   = pend_end_ff;
      pend_err_in   = pend_err_ff;
      if (emit_any) begin
         pend_valid_in = 1'b1;
         pend_char_in  = cmd.emit_top ? top : (cmd.emit_sym ? sym_ff : 8'd0);
         pend_end_in   = cmd.emit_term;
         pend_err_in   = cmd.emit_term ? term_err : ERR_NONE;
      end else if (cmd.finish) begin
         pend_valid_in = 1'b0;
      end
      out_valid_in = move | (out_valid_ff & !rsp_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff      <= '0;
         ovf_ff        <= 1'b0;
         unk_ff        <= 1'b0;
         pend_valid_ff <= 1'b0;
         out_valid_ff  <= 1'b0;
      end else begin
         count_ff      <= count_in;
         ovf_ff        <= ovf_in;
         unk_ff        <= unk_in;
         pend_valid_ff <= pend_valid_in;
         out_valid_ff  <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pend_char_ff <= pend_char_in;
      pend_end_ff  <= pend_end_in;
      pend_err_ff  <= pend_err_in;
      if (move) begin
         out_char_ff <= pend_char_ff;
         out_last_ff <= move_last;
         out_end_ff  <= pend_end_ff;
         out_err_ff  <= pend_err_ff;
      end
   end

   always_comb begin
      stat.kind        = classify(sym_ff, end_ff);
      stat.count_zero  = (count_ff == '0);
      stat.count_one   = (count_ff == CW'(1));
      stat.top_is_open = (top == CHAR_OPEN);
      stat.top_ge      = (prec_of(top) >= prec_of(sym_ff));
      stat.emit_ok     = !pend_valid_ff || out_free;
      stat.finish_ok   = !pend_valid_ff || out_free;
   end

   assign rsp_valid       = out_valid_ff;
   assign rsp_out_char    = out_char_ff;
   assign rsp_last_of_run = out_last_ff;
   assign rsp_end_of_expr = out_end_ff;
   assign rsp_error_code  = out_err_ff;

endmodule

`default_nettype wire

[rtl/infix_to_postfix_converter_core.sv]
// Top level of the infix to postfix converter (shunting-yard).
// Depends on i2p_pkg, i2p_ctrl, i2p_datapath and i2p_ram.
//
//   channel | ports                                          | direction
//   req     | req_valid/ready, req_symbol, req_is_end        | in
//   rsp     | rsp_valid/ready, rsp_out_char, rsp_last_of_run,| out
//           | rsp_end_of_expr, rsp_error_code                |
//
// One item at a time: accept and decode, then for each stack entry examined
// one stack RAM read followed by compare and pop, then a push after
// examining, the terminator, and a step to close the run for any operand,
// end or examining item; a bare push or drop needs only accept and decode.
// Results pass through one pending slot and a result register; the
// sequencer holds while both are occupied and rsp_ready is low.
// Reset clears the stack count, error flags and valid bits; no clearing pass.
`default_nettype none

module infix_to_postfix_converter_core #(
   parameter int STACK_DEPTH = 32
) (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_ready,
   input  wire logic [7:0] req_symbol,
   input  wire logic       req_is_end,
   output logic            rsp_valid,
   input  wire logic       rsp_ready,
   output logic      [7:0] rsp_out_char,
   output logic            rsp_last_of_run,
   output logic            rsp_end_of_expr,
   output logic      [1:0] rsp_error_code
);
   import i2p_pkg::*;

   ctl_cmd_type  cmd;
   ctl_stat_type stat;

   i2p_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   i2p_datapath #(
      .STACK_DEPTH (STACK_DEPTH)
   ) u_dp (
      .clock           (clock),
      .reset           (reset),
      .req_symbol      (req_symbol),
      .req_is_end      (req_is_end),
      .cmd             (cmd),
      .stat            (stat),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_out_char    (rsp_out_char),
      .rsp_last_of_run (rsp_last_of_run),
      .rsp_end_of_expr (rsp_end_of_expr),
      .rsp_error_code  (rsp_error_code)
   );

endmodule

`default_nettype wire

[rtl/i2p_port_checker.sv]
// Port-level checks for the converter's result channel, bound to the top.
// Depends on i2p_pkg and infix_to_postfix_converter_core.
`default_nettype none

module i2p_port_checker (
   input wire logic       clock,
   input wire logic       reset,
   input wire logic       rsp_valid,
   input wire logic       rsp_ready,
   input wire logic [7:0] rsp_out_char,
   input wire logic       rsp_last_of_run,
   input wire logic       rsp_end_of_expr,
   input wire logic [1:0] rsp_error_code
);
   import i2p_pkg::*;

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_out_char) &&
      $stable(rsp_last_of_run) && $stable(rsp_end_of_expr) && $stable(rsp_error_code))
      else $error("result item changed while stalled");

   a_term_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_end_of_expr |-> rsp_last_of_run && rsp_out_char == 8'd0)
      else $error("terminator not last or carries a character");

   a_err_only_term: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_end_of_expr |-> rsp_error_code == ERR_NONE)
      else $error("error code on a non-terminator item");

   a_err_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_error_code <= ERR_UNKNOWN)
      else $error("undefined error code");

endmodule

bind infix_to_postfix_converter_core i2p_port_checker u_port_checker (
   .clock           (clock),
   .reset           (reset),
   .rsp_valid       (rsp_valid),
   .rsp_ready       (rsp_ready),
   .rsp_out_char    (rsp_out_char),
   .rsp_last_of_run (rsp_last_of_run),
   .rsp_end_of_expr (rsp_end_of_expr),
   .rsp_error_code  (rsp_error_code)
);

`default_nettype wire
